// File: rtl/pidtg_pkg.sv
// ----------------------------------------------------------------------------
// pidtg_pkg
// shared types, constants and register indexes for the time-gated pid unit
// ----------------------------------------------------------------------------
package pidtg_pkg;

    localparam int DataWidth = 16;
    localparam int GainWidth = 16;
    localparam int TickWidth = 16;
    localparam int CfgIdxWidth = 3;
    localparam int AccWidth = 32;
    localparam int WideWidth = 64;
    localparam int QuotWidth = 34;

    localparam logic [CfgIdxWidth-1:0] RegGainProp = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegGainInteg = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegGainDeriv = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegSamplePeriod = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegLimitHigh = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegLimitLow = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegSetpoint = 3'd6;

    typedef enum logic [2:0] {
        OP_IDLE = 3'b001,
        OP_STEP = 3'b010,
        OP_DIV  = 3'b100
    } op_t;

    typedef struct packed {
        logic load;
        logic step;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic gated;
        logic last_step;
    } ctrl_stat_t;

endpackage

// File: rtl/pidtg_datapath.sv
// ----------------------------------------------------------------------------
// pidtg_datapath
// configuration registers, state, shared multiplier and serial divider
// ----------------------------------------------------------------------------
module pidtg_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pidtg_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  logic [pidtg_pkg::DataWidth-1:0]       cfg_data,
    input  logic signed [pidtg_pkg::DataWidth-1:0] measurement,
    input  logic [pidtg_pkg::TickWidth-1:0]       elapsed_ticks,
    input  pidtg_pkg::ctrl_cmd_t                  cmd,
    input  logic [2:0]                            step_idx,
    output pidtg_pkg::ctrl_stat_t                 stat,
    output logic [5:0]                            div_cnt,
    output logic signed [pidtg_pkg::DataWidth-1:0] drive,
    output logic                                  updated
);

    localparam int W = pidtg_pkg::WideWidth;
    localparam int QW = pidtg_pkg::QuotWidth;

    logic signed [15:0] kp_reg, ki_reg, kd_reg, hi_reg, lo_reg, sp_reg;
    logic [15:0] per_reg;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [15:0] last_meas_reg, last_drive_reg;
    logic signed [15:0] meas_reg;
    logic [15:0] el_reg;
    logic signed [16:0] err_reg;
    logic signed [W-1:0] a_reg, b_reg, sum_reg;
    logic [QW-1:0] rem_reg, quot_reg;
    logic neg_reg;
    logic [5:0] cnt_reg;
    logic signed [15:0] out_drive_reg;
    logic out_upd_reg;
    logic fin_reg;
    logic fin2_reg;

    logic signed [W-1:0] hi_q, lo_q, prod, sum_c, rnd;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] prod_raw;
    logic signed [W-1:0] clamp_in, clamp_out;
    logic [QW:0] rem_sh;
    logic [QW-1:0] dvd_mag;

    assign hi_q = W'(hi_reg) <<< 16;
    assign lo_q = W'(lo_reg) <<< 16;

    always_comb
    begin
        priority if (clamp_in > hi_q)
            clamp_out = hi_q;
        else if (clamp_in < lo_q)
            clamp_out = lo_q;
        else
            clamp_out = clamp_in;
    end

    // operand select for the shared 34x18 multiplier
    always_comb
    begin
        unique case (step_idx)
            3'd0: begin mul_a = 34'(err_reg); mul_b = 18'(kp_reg); end
            3'd1: begin mul_a = 34'(err_reg); mul_b = 18'(ki_reg); end
            3'd2: begin mul_a = a_reg[33:0]; mul_b = 18'($signed({1'b0, el_reg})); end
            3'd3: begin
                mul_a = 34'(meas_reg) - 34'(last_meas_reg);
                mul_b = 18'(kd_reg);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign prod_raw = mul_a * mul_b;
    assign prod = W'(prod_raw);
    assign clamp_in = (step_idx == 3'd3) ? (W'(integ_reg) + (b_reg <<< 8))
                                         : sum_reg;
    assign integ_next = 32'(clamp_out);
    assign rem_sh = {rem_reg, quot_reg[QW-1]};
    assign dvd_mag = prod[W-1] ? QW'(-prod) : QW'(prod);
    assign sum_c = sum_reg;
    assign rnd = sum_c + 64'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0; ki_reg <= '0; kd_reg <= '0;
            per_reg <= 16'd1;
            hi_reg <= 16'sh7fff; lo_reg <= 16'sh8000; sp_reg <= '0;
            integ_reg <= '0; last_meas_reg <= '0; last_drive_reg <= '0;
            meas_reg <= '0; el_reg <= '0; err_reg <= '0;
            a_reg <= '0; b_reg <= '0; sum_reg <= '0;
            rem_reg <= '0; quot_reg <= '0; neg_reg <= 1'b0;
            out_drive_reg <= '0;
            out_upd_reg <= 1'b0; cnt_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pidtg_pkg::RegGainProp:  kp_reg <= cfg_data;
                    pidtg_pkg::RegGainInteg: ki_reg <= cfg_data;
                    pidtg_pkg::RegGainDeriv: kd_reg <= cfg_data;
                    pidtg_pkg::RegSamplePeriod:
                        per_reg <= (cfg_data == '0) ? 16'd1 : cfg_data;
                    pidtg_pkg::RegLimitHigh: hi_reg <= cfg_data;
                    pidtg_pkg::RegLimitLow:  lo_reg <= cfg_data;
                    pidtg_pkg::RegSetpoint:  sp_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                meas_reg <= measurement;
                el_reg <= elapsed_ticks;
                err_reg <= 17'(sp_reg) - 17'(measurement);
                out_drive_reg <= last_drive_reg;
                out_upd_reg <= 1'b0;
            end
            if (cmd.step)
            begin
                unique case (step_idx)
                    3'd0: sum_reg <= prod <<< 8;
                    3'd1: a_reg <= prod;
                    3'd2: b_reg <= prod;
                    3'd3: begin
                        integ_reg <= integ_next;
                        sum_reg <= sum_reg + W'(integ_next);
                        neg_reg <= prod[W-1];
                        quot_reg <= dvd_mag;
                        rem_reg <= '0;
                        cnt_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (rem_sh >= (QW+1)'(el_reg))
                begin
                    rem_reg <= QW'(rem_sh - (QW+1)'(el_reg));
                    quot_reg <= {quot_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= QW'(rem_sh);
                    quot_reg <= {quot_reg[QW-2:0], 1'b0};
                end
            end
            if (cmd.commit)
            begin
                sum_reg <= sum_reg - ((neg_reg ? -W'(quot_reg) : W'(quot_reg)) <<< 8);
            end
            // final clamp happens on the cycle after commit
            fin_reg <= cmd.commit;
            if (fin_reg)
                sum_reg <= clamp_out;
            if (stat.last_step)
            begin
                last_drive_reg <= 16'(rnd >>> 16);
                out_drive_reg <= 16'(rnd >>> 16);
                last_meas_reg <= meas_reg;
                out_upd_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin2_reg <= 1'b0;
        else
            fin2_reg <= fin_reg;
    end

    assign stat.gated = (elapsed_ticks < per_reg);
    assign stat.last_step = fin2_reg;
    assign div_cnt = cnt_reg;
    assign drive = out_drive_reg;
    assign updated = out_upd_reg;

    a_per_nonzero: assert property (@(posedge clk) disable iff (!rst_n) per_reg != '0)
        else $error("sample period zero");
    a_integ_hi: assert property (@(posedge clk) disable iff (!rst_n)
        $past(stat.last_step) && hi_reg >= lo_reg |-> integ_reg <= (32'(hi_reg) <<< 16))
        else $error("integral above limit");
    a_fin_seq: assert property (@(posedge clk) disable iff (!rst_n)
        fin_reg |-> $past(cmd.commit))
        else $error("finish without commit");

endmodule

// File: rtl/pidtg_ctrl.sv
// ----------------------------------------------------------------------------
// pidtg_ctrl
// sequencer for one update: multiplies, serial divide, finish, output beat
// ----------------------------------------------------------------------------
module pidtg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  pidtg_pkg::ctrl_stat_t stat,
    input  logic [5:0]            div_cnt,
    output pidtg_pkg::ctrl_cmd_t  cmd,
    output logic [2:0]            step_idx
);

    pidtg_pkg::op_t state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic busy_reg, busy_next;
    logic ov_reg, ov_next;
    logic [1:0] tail_reg, tail_next;
    logic in_acc;

    assign in_ready = !busy_reg && (!ov_reg || out_ready);
    assign in_acc = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign step_idx = idx_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        busy_next = busy_reg;
        tail_next = tail_reg;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        unique case (state_reg)
            pidtg_pkg::OP_IDLE:
            begin
                if (tail_reg != 2'd0)
                begin
                    tail_next = tail_reg - 2'd1;
                    if (tail_reg == 2'd1)
                    begin
                        busy_next = 1'b0;
                        ov_next = 1'b1;
                    end
                end
                else if (in_acc)
                begin
                    cmd.load = 1'b1;
                    if (stat.gated)
                        ov_next = 1'b1;
                    else
                    begin
                        busy_next = 1'b1;
                        idx_next = 3'd0;
                        state_next = pidtg_pkg::OP_STEP;
                    end
                end
            end
            pidtg_pkg::OP_STEP:
            begin
                cmd.step = 1'b1;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd3)
                    state_next = pidtg_pkg::OP_DIV;
            end
            pidtg_pkg::OP_DIV:
            begin
                if (div_cnt == 6'(pidtg_pkg::QuotWidth))
                begin
                    cmd.commit = 1'b1;
                    tail_next = 2'd3;
                    state_next = pidtg_pkg::OP_IDLE;
                end
                else
                    cmd.div_step = 1'b1;
            end
            default: state_next = pidtg_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidtg_pkg::OP_IDLE;
            idx_reg <= '0;
            busy_reg <= 1'b0;
            ov_reg <= 1'b0;
            tail_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            busy_reg <= busy_next;
            ov_reg <= ov_next;
            tail_reg <= tail_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_busy_noready: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready)
        else $error("ready while busy");
    a_commit_tail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> tail_reg == 2'd3)
        else $error("tail not started");

endmodule

// File: rtl/pid_controller_time_gated_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_time_gated_unit
// time-gated pid controller with derivative on measurement
// ----------------------------------------------------------------------------
// A beat whose elapsed ticks fall below the sample period is answered with the
// previous drive in the cycle after acceptance. An update runs four passes
// through the shared multiplier, a 34-step restoring divide of the derivative
// term by the elapsed ticks, commit, clamp, rounding and raising the output.
// One beat is in work at a time, so no new beat is taken before the last one
// is through; a new beat can be taken in the cycle the result is taken.
module pid_controller_time_gated_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pidtg_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  logic [pidtg_pkg::DataWidth-1:0]        cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [pidtg_pkg::DataWidth-1:0] measurement,
    input  logic [pidtg_pkg::TickWidth-1:0]        elapsed_ticks,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [pidtg_pkg::DataWidth-1:0] drive,
    output logic                                   updated
);

    pidtg_pkg::ctrl_cmd_t  cmd;
    pidtg_pkg::ctrl_stat_t stat;
    logic [2:0] step_idx;
    logic [5:0] div_cnt;

    pidtg_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .div_cnt(div_cnt), .cmd(cmd), .step_idx(step_idx)
    );

    pidtg_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .measurement(measurement), .elapsed_ticks(elapsed_ticks),
        .cmd(cmd), .step_idx(step_idx), .stat(stat), .div_cnt(div_cnt),
        .drive(drive), .updated(updated)
    );

endmodule
